// ----- rtl/core/grc_pkg.sv -----
// shared types, constants and sine lookup for the wall column raycaster
`timescale 1ns / 1ps
package grc_pkg;

  localparam int unsigned MaxSteps    = 2048;
  localparam int unsigned StepW       = 12;
  localparam int unsigned DivW        = 25;
  localparam int unsigned DenW        = 17;
  localparam logic [10:0] StepQ16     = 11'd1311;
  localparam logic [15:0] FracLow     = 16'd655;
  localparam logic [15:0] FracHigh    = 16'd64880;
  localparam logic [24:0] HeightNum   = 25'd4423680;
  localparam logic [14:0] FovReset    = 15'd10923;
  localparam logic [10:0] RayCntReset = 11'd256;

  localparam logic [2:0] RegMap0 = 3'd0;
  localparam logic [2:0] RegMap1 = 3'd1;
  localparam logic [2:0] RegMap2 = 3'd2;
  localparam logic [2:0] RegMap3 = 3'd3;
  localparam logic [2:0] RegFov  = 3'd4;
  localparam logic [2:0] RegRays = 3'd5;

  typedef enum logic [9:0] {
    StIdle  = 10'b00_0000_0001,
    StDivA  = 10'b00_0000_0010,
    StCos   = 10'b00_0000_0100,
    StSin   = 10'b00_0000_1000,
    StCorr  = 10'b00_0001_0000,
    StMarch = 10'b00_0010_0000,
    StDist  = 10'b00_0100_0000,
    StScale = 10'b00_1000_0000,
    StDivH  = 10'b01_0000_0000,
    StOut   = 10'b10_0000_0000
  } state_e;

  localparam logic [14:0] SINE_TAB [65] = '{
    15'd0, 15'd402, 15'd804, 15'd1205, 15'd1606, 15'd2006, 15'd2404, 15'd2801,
    15'd3196, 15'd3590, 15'd3981, 15'd4370, 15'd4756, 15'd5139, 15'd5520,
    15'd5897, 15'd6270, 15'd6639, 15'd7005, 15'd7366, 15'd7723, 15'd8076,
    15'd8423, 15'd8765, 15'd9102, 15'd9434, 15'd9760, 15'd10080, 15'd10394,
    15'd10702, 15'd11003, 15'd11297, 15'd11585, 15'd11866, 15'd12140,
    15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395, 15'd13623,
    15'd13842, 15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811,
    15'd14978, 15'd15137, 15'd15286, 15'd15426, 15'd15557, 15'd15679,
    15'd15791, 15'd15893, 15'd15986, 15'd16069, 15'd16143, 15'd16207,
    15'd16261, 15'd16305, 15'd16340, 15'd16364, 15'd16379, 15'd16384
  };

  function automatic logic signed [15:0] sine_q14(input logic [15:0] a);
    logic [14:0] r;
    logic [6:0]  idx;
    logic [14:0] lo;
    logic [14:0] hi;
    logic [16:0] prod;
    logic [14:0] v;
    r = a[14] ? (15'h4000 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
    idx = r[14:8];
    lo = SINE_TAB[idx];
    hi = (idx >= 7'd64) ? lo : SINE_TAB[7'(idx + 7'd1)];
    prod = 17'(9'(hi - lo) * r[7:0]);
    v = (idx >= 7'd64) ? 15'd16384 : 15'(lo + {6'd0, prod[16:8]});
    return a[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage

// ----- rtl/core/grid_raycast_wall_column.sv -----
// wall column raycaster top level with march sequencer and shared divider
`timescale 1ns / 1ps
// One request is taken when the block is idle and yields one result. The ray angle
// needs a serial restoring divide, then the StCos, StSin and StCorr states use the
// shared sine unit to set up the step vector and the fisheye factor. The march then
// advances by one 0.02-tile step at a time (at most 2048 steps), the StDist and
// StScale multiplies and a second serial divide give the wall height, and the StOut
// state loads the output register once it is free. The result waits in the output
// register while the next request is taken. Map and view registers are written
// through the APB port at byte address 8*index.
module grid_raycast_wall_column (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // player_x[15:0], player_y[31:16], view_angle[47:32], column[57:48]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // column_out[9:0], perp_distance[26:10], wall_height[38:27], texture_column[44:39]
  output logic [47:0] m_axis_tdata,
  // hit_wall[0]
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  grc_pkg::state_e state_q, state_d;

  logic [63:0] map_q [4];
  logic [14:0] fov_q;
  logic [10:0] rays_q;

  logic [9:0]  col_q;
  logic [15:0] view_q;
  logic [15:0] offset_q;
  logic signed [15:0] sin_q;
  logic signed [15:0] corr_q;
  logic signed [26:0] sx_q, sy_q;
  logic signed [36:0] x_q, y_q;
  logic [grc_pkg::StepW-1:0] n_q;
  logic        hit_q;
  logic [22:0] p_q;
  logic [16:0] dist_q;

  logic [grc_pkg::DivW-1:0] num_q;
  logic [grc_pkg::DenW-1:0] den_q, rem_q;
  logic [4:0]  cnt_q;

  logic [47:0] out_data_q;
  logic        out_hit_q;
  logic        out_valid_q;

  logic [2:0]  reg_idx;
  logic        wr_en;
  logic [17:0] trial;
  logic        trial_ge;
  logic [15:0] offset_n;
  logic [15:0] ray;
  logic [15:0] sine_arg;
  logic signed [15:0] sine_val;
  logic signed [36:0] x_n, y_n;
  logic        out_map;
  logic        wall;
  logic [3:0]  row, cl;
  logic [63:0] row_word;
  logic [37:0] dprod;
  logic [15:0] fx, fy, tc;
  logic [11:0] height;
  logic        out_free;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) map_q[i] <= '0;
      fov_q  <= grc_pkg::FovReset;
      rays_q <= grc_pkg::RayCntReset;
    end else if (wr_en) begin
      case (reg_idx)
        grc_pkg::RegMap0: map_q[0] <= pwdata;
        grc_pkg::RegMap1: map_q[1] <= pwdata;
        grc_pkg::RegMap2: map_q[2] <= pwdata;
        grc_pkg::RegMap3: map_q[3] <= pwdata;
        grc_pkg::RegFov:  fov_q    <= pwdata[14:0];
        grc_pkg::RegRays: rays_q   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      grc_pkg::RegMap0: prdata = map_q[0];
      grc_pkg::RegMap1: prdata = map_q[1];
      grc_pkg::RegMap2: prdata = map_q[2];
      grc_pkg::RegMap3: prdata = map_q[3];
      grc_pkg::RegFov:  prdata = {49'd0, fov_q};
      grc_pkg::RegRays: prdata = {53'd0, rays_q};
      default:          prdata = '0;
    endcase
  end

  // shared restoring divider step
  assign trial    = {rem_q, num_q[grc_pkg::DivW-1]};
  assign trial_ge = trial >= {1'b0, den_q};

  // shared sine unit
  assign offset_n = 16'(num_q[15:0] - {2'd0, fov_q[14:1]});
  assign ray = 16'(view_q + offset_n);
  always_comb begin
    case (state_q)
      grc_pkg::StCos: sine_arg = 16'(ray + 16'h4000);
      grc_pkg::StSin: sine_arg = ray;
      default:        sine_arg = 16'(offset_q + 16'h4000);
    endcase
  end
  assign sine_val = grc_pkg::sine_q14(sine_arg);

  // march step
  assign x_n = x_q + {{10{sx_q[26]}}, sx_q};
  assign y_n = y_q + {{10{sy_q[26]}}, sy_q};
  assign out_map = x_n[36] || (x_n[35:34] != 2'd0) || y_n[36] || (y_n[35:34] != 2'd0);
  assign row = y_n[33:30];
  assign cl  = x_n[33:30];
  assign row_word = map_q[row[3:2]];
  assign wall = row_word[{row[1:0], cl}];

  assign dprod = 38'(p_q * corr_q[14:0]);

  assign fx = x_q[29:14];
  assign fy = y_q[29:14];
  assign tc = (fx < grc_pkg::FracLow || fx > grc_pkg::FracHigh) ? fy : fx;
  assign height = (dist_q == 17'd0 || num_q > 25'd4095) ? 12'd4095 : num_q[11:0];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == grc_pkg::StIdle);

  always_comb begin
    state_d = state_q;
    case (state_q)
      grc_pkg::StIdle:  if (s_axis_tvalid) state_d = grc_pkg::StDivA;
      grc_pkg::StDivA:  if (cnt_q == 5'd0) state_d = grc_pkg::StCos;
      grc_pkg::StCos:   state_d = grc_pkg::StSin;
      grc_pkg::StSin:   state_d = grc_pkg::StCorr;
      grc_pkg::StCorr:  state_d = grc_pkg::StMarch;
      grc_pkg::StMarch: begin
        if (out_map || wall || n_q == 12'(grc_pkg::MaxSteps - 1)) state_d = grc_pkg::StDist;
      end
      grc_pkg::StDist:  state_d = grc_pkg::StScale;
      grc_pkg::StScale: state_d = grc_pkg::StDivH;
      grc_pkg::StDivH:  if (cnt_q == 5'd0) state_d = grc_pkg::StOut;
      grc_pkg::StOut:   if (out_free) state_d = grc_pkg::StIdle;
      default:          state_d = grc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= grc_pkg::StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == grc_pkg::StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == grc_pkg::StIdle || state_q == grc_pkg::StScale) begin
        cnt_q <= 5'(grc_pkg::DivW - 1);
      end else if (cnt_q != 5'd0) begin
        cnt_q <= 5'(cnt_q - 5'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      grc_pkg::StIdle: begin
        x_q    <= {3'd0, s_axis_tdata[15:0], 18'd0};
        y_q    <= {3'd0, s_axis_tdata[31:16], 18'd0};
        view_q <= s_axis_tdata[47:32];
        col_q  <= s_axis_tdata[57:48];
        num_q  <= 25'(s_axis_tdata[57:48] * fov_q);
        den_q  <= (rays_q == 11'd0) ? 17'd1 : {6'd0, rays_q};
        rem_q  <= '0;
        n_q    <= '0;
        hit_q  <= 1'b0;
      end
      grc_pkg::StDivA, grc_pkg::StDivH: begin
        rem_q <= trial_ge ? 17'(trial - {1'b0, den_q}) : trial[16:0];
        num_q <= {num_q[grc_pkg::DivW-2:0], trial_ge};
      end
      grc_pkg::StCos: begin
        offset_q <= offset_n;
      end
      grc_pkg::StSin: begin
        sx_q  <= 27'(sin_q * $signed({1'b0, grc_pkg::StepQ16}));
      end
      grc_pkg::StCorr: begin
        sy_q   <= 27'(sin_q * $signed({1'b0, grc_pkg::StepQ16}));
        corr_q <= sine_val;
      end
      grc_pkg::StMarch: begin
        x_q   <= x_n;
        y_q   <= y_n;
        n_q   <= 12'(n_q + 12'd1);
        hit_q <= !out_map && wall;
      end
      grc_pkg::StDist: begin
        p_q <= 23'(n_q * grc_pkg::StepQ16);
      end
      grc_pkg::StScale: begin
        if (corr_q[15] || corr_q == 16'sd0) begin
          dist_q <= '0;
          den_q  <= 17'd1;
        end else if (dprod[37:18] > 20'd131071) begin
          dist_q <= 17'd131071;
          den_q  <= 17'd131071;
        end else begin
          dist_q <= dprod[34:18];
          den_q  <= (dprod[34:18] == 17'd0) ? 17'd1 : dprod[34:18];
        end
        num_q <= grc_pkg::HeightNum;
        rem_q <= '0;
      end
      grc_pkg::StOut: begin
        if (out_free) begin
          out_data_q <= {3'd0, tc[15:10], height, dist_q, col_q};
          out_hit_q  <= hit_q;
        end
      end
      default: ;
    endcase
    if (state_q == grc_pkg::StCos || state_q == grc_pkg::StSin) sin_q <= sine_val;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_hit_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state register not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == grc_pkg::StMarch |-> n_q < 12'(grc_pkg::MaxSteps))
    else $error("step count beyond limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == grc_pkg::StDivA &&
      cnt_q == 5'(grc_pkg::DivW - 1))
    else $error("divider not started on transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == grc_pkg::StOut && out_free |=> m_axis_tvalid && state_q == grc_pkg::StIdle)
    else $error("result not presented");

endmodule

// ----- tb/tb_grid_raycast_wall_column.sv -----
// self-checking testbench for the wall column raycaster with a ray march scoreboard
`timescale 1ns / 1ps

class ray_scoreboard;
  logic [63:0] walls [4];
  logic [14:0] fov;
  logic [10:0] rays;
  logic [47:0] pend_data [$];
  logic        pend_hit [$];
  int          errors;

  function new();
    for (int i = 0; i < 4; i++) walls[i] = '0;
    fov = 15'd10923;
    rays = 11'd256;
    errors = 0;
  endfunction

  function void set_reg(int idx, logic [63:0] v);
    if (idx < 4) walls[idx] = v;
    else if (idx == 4) fov = v[14:0];
    else if (idx == 5) rays = v[10:0];
  endfunction

  function int sine(logic [31:0] ang);
    logic [15:0] a;
    int r, ix, fr, v;
    int tab [65] = '{0, 402, 804, 1205, 1606, 2006, 2404, 2801, 3196, 3590,
      3981, 4370, 4756, 5139, 5520, 5897, 6270, 6639, 7005, 7366,
      7723, 8076, 8423, 8765, 9102, 9434, 9760, 10080, 10394, 10702,
      11003, 11297, 11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
      13623, 13842, 14053, 14256, 14449, 14635, 14811, 14978, 15137, 15286,
      15426, 15557, 15679, 15791, 15893, 15986, 16069, 16143, 16207, 16261,
      16305, 16340, 16364, 16379, 16384};
    a = ang[15:0];
    r = a[13:0];
    if (a[14]) r = 16384 - r;
    ix = r >> 8;
    fr = r & 255;
    if (ix >= 64) v = 16384;
    else v = tab[ix] + (((tab[ix + 1] - tab[ix]) * fr) >> 8);
    return a[15] ? -v : v;
  endfunction

  function bit wall_at(longint row, longint col);
    logic [63:0] w;
    if (row >= 16 || col >= 16) return 0;
    w = walls[row >> 2];
    return w[16 * (row & 3) + col];
  endfunction

  function void note_request(logic [63:0] d);
    longint px, py, view, col, rc, offs, ray, sx, sy, x, y, lim, pdist, hgt, fx, fy, tc;
    int n, corr;
    bit hit;
    logic [47:0] exp_d;
    px = d[15:0]; py = d[31:16]; view = d[47:32]; col = d[57:48];
    rc = (rays == 0) ? 1 : rays;
    offs = ((col * fov) / rc - (fov >> 1)) & 64'hFFFF;
    ray = (view + offs) & 64'hFFFF;
    sx = longint'(sine(ray + 32'h4000)) * 1311;
    sy = longint'(sine(ray)) * 1311;
    x = px * 262144;
    y = py * 262144;
    lim = 64'd16 * 64'd1073741824;
    n = 0;
    hit = 0;
    while (n < 2048) begin
      x += sx;
      y += sy;
      n++;
      if (x < 0 || x >= lim || y < 0 || y >= lim) break;
      if (wall_at(y / 1073741824, x / 1073741824)) begin
        hit = 1;
        break;
      end
    end
    corr = sine(offs + 32'h4000);
    pdist = (corr <= 0) ? 0 : ((longint'(n) * 1311 * corr) >>> 18);
    if (pdist > 131071) pdist = 131071;
    hgt = (pdist == 0) ? 4095 : (64'd4423680 / pdist);
    if (hgt > 4095) hgt = 4095;
    fx = (x & 64'h3FFFFFFF) >> 14;
    fy = (y & 64'h3FFFFFFF) >> 14;
    tc = (fx < 655 || fx > 64880) ? fy : fx;
    exp_d = {3'd0, 6'((tc * 64) >> 16), 12'(hgt), 17'(pdist), 10'(col)};
    pend_data = {pend_data, exp_d};
    pend_hit = {pend_hit, hit};
  endfunction

  function void check_result(logic [47:0] d, logic h);
    logic [47:0] e;
    logic eh;
    if (pend_data.size() == 0) begin
      $error("unexpected result column_out %0d", d[9:0]);
      errors++;
      return;
    end
    e = pend_data.pop_front();
    eh = pend_hit.pop_front();
    if (d[9:0] !== e[9:0]) begin
      $error("column_out exp %0d got %0d", e[9:0], d[9:0]); errors++;
    end
    if (d[26:10] !== e[26:10]) begin
      $error("perp_distance exp %0d got %0d", e[26:10], d[26:10]); errors++;
    end
    if (d[38:27] !== e[38:27]) begin
      $error("wall_height exp %0d got %0d", e[38:27], d[38:27]); errors++;
    end
    if (d[44:39] !== e[44:39]) begin
      $error("texture_column exp %0d got %0d", e[44:39], d[44:39]); errors++;
    end
    if (h !== eh) begin
      $error("hit_wall exp %0d got %0d", eh, h); errors++;
    end
  endfunction
endclass

module tb_grid_raycast_wall_column;
  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        psel, penable, pwrite, pready;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;
  ray_scoreboard sb;
  bit          calm;

  grid_raycast_wall_column DUT (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("status: fail");
    $finish;
  end

  task automatic write_reg(int idx, logic [63:0] v);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 6'(8 * idx); pwdata <= v;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_ray(logic [15:0] px, logic [15:0] py, logic [15:0] va,
                          logic [9:0] col);
    logic [63:0] d;
    d = {6'd0, col, va, py, px};
    while (!calm && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tdata <= d;
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(d);
    @(negedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 0;
    while (sb.pend_data.size() != 0) begin
      @(posedge clk_i);
      guard++;
      if (guard > 2000000) begin
        $display("status: fail");
        $finish;
      end
    end
    repeat (1300) @(posedge clk_i);
  endtask

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);

  always @(negedge clk_i)
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 10);

  task automatic random_rays(int cnt, int maxcol);
    for (int i = 0; i < cnt; i++)
      send_ray(16'($urandom), 16'($urandom), 16'($urandom),
               10'($urandom_range(maxcol)));
  endtask

  initial begin
    sb = new();
    rst_ni = 0; s_axis_tvalid = 0; s_axis_tdata = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0; calm = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    // directed: empty map, reset view settings
    send_ray(16'h0000, 16'h0000, 16'h0000, 10'd0);
    send_ray(16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1023);
    send_ray(16'h8000, 16'h8000, 16'h4000, 10'd128);
    send_ray(16'h8000, 16'h8000, 16'h8000, 10'd255);
    send_ray(16'h8000, 16'h8000, 16'hC000, 10'd300);
    drain();
    // border walls with a pillar
    write_reg(0, 64'h8001_8001_8001_FFFF);
    write_reg(1, 64'h8001_8181_8181_8001);
    write_reg(2, 64'h8001_8001_8001_8001);
    write_reg(3, 64'hFFFF_8001_8001_8001);
    write_reg(4, 64'hFFFF_FFFF_FFFF_7FFF);
    write_reg(5, 64'hFFFF_FFFF_FFFF_F800);
    send_ray(16'h3800, 16'h3800, 16'h0000, 10'd0);
    send_ray(16'h3800, 16'h3800, 16'h2000, 10'd1023);
    send_ray(16'h1800, 16'h1800, 16'h6000, 10'd512);
    send_ray(16'h0800, 16'h0800, 16'hA000, 10'd5);
    drain();
    write_reg(4, 64'd1);
    write_reg(5, 64'd1024);
    send_ray(16'h2000, 16'h2000, 16'h0000, 10'd1023);
    send_ray(16'h7000, 16'h2000, 16'h4000, 10'd0);
    send_ray(16'h1010, 16'h1010, 16'h0000, 10'd1);
    send_ray(16'h0001, 16'h0001, 16'h8000, 10'd0);
    drain();
    write_reg(4, 64'd32767);
    write_reg(5, 64'd1);
    send_ray(16'h8000, 16'h8000, 16'h1234, 10'd0);
    send_ray(16'h8000, 16'h8000, 16'h1234, 10'd3);
    drain();
    // random phases over random maps and view settings
    for (int p = 0; p < 8; p++) begin
      for (int w = 0; w < 4; w++)
        write_reg(w, {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
      write_reg(4, (p == 0) ? 64'd32767 : 64'($urandom_range(32767, 1)));
      write_reg(5, (p == 1) ? 64'd0 : 64'($urandom_range(1024, 1)));
      calm = (p == 3);
      random_rays(60, 1023);
      drain();
    end
    calm = 0;
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ----- grid_raycast_wall_column.f -----
rtl/core/grc_pkg.sv
rtl/core/grid_raycast_wall_column.sv
tb/tb_grid_raycast_wall_column.sv
